// ----- src/disc_reveal_bitmap_defines.svh -----
// Assertion macros used by the port checker file.
`ifndef DISC_REVEAL_BITMAP_DEFINES_SVH
`define DISC_REVEAL_BITMAP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("disc_reveal_bitmap check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("disc_reveal_bitmap check failed");

`endif

// ----- src/drb_pkg.sv -----
// Package of the disc reveal bitmap: sizes, codes, reset values and the span table.
package drb_pkg;

  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_RADIUS = 15;

  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_CW = 9;

  localparam int WORLD_W  = 24;
  localparam int DIV_W    = 25;
  localparam int DEN_W    = 16;
  localparam int CTR_W    = 18;
  localparam int POS_W    = 19;
  localparam int CENTER_LIMIT = 65536;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [1:0] {
    CMD_DISC = 2'd0,
    CMD_CELL = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd4;

  localparam logic [6:0]       RST_GRID_COLS = 7'd64;
  localparam logic [6:0]       RST_GRID_ROWS = 7'd64;
  localparam logic [DEN_W-1:0] RST_CELL_SIZE = 16'd8192;

  // Half span of a disc row: largest w with w*w + a*a <= r*r.
  function automatic logic [3:0] half_width(input logic [3:0] r, input logic [3:0] a);
    logic [8:0] rr;
    logic [8:0] aa;
    logic [3:0] w;
    rr = 9'(r) * 9'(r);
    aa = 9'(a) * 9'(a);
    w  = '0;
    for (int k = 0; k <= MAX_RADIUS; k++) begin
      if (9'(k * k) + aa <= rr) w = 4'(k);
    end
    return w;
  endfunction

endpackage

// ----- src/drb_in_if.sv -----
// Command channel: valid/ready handshake with the command payload.
interface drb_in_if;
  logic              valid;
  logic              ready;
  drb_pkg::cmd_t     cmd;
  logic signed [23:0] world_x;
  logic signed [23:0] world_y;
  logic [3:0]        radius;
  logic signed [7:0] cell_x;
  logic signed [7:0] cell_y;

  modport source (output valid, cmd, world_x, world_y, radius, cell_x, cell_y,
                  input ready);
  modport sink   (input valid, cmd, world_x, world_y, radius, cell_x, cell_y,
                  output ready);
endinterface

// ----- src/drb_out_if.sv -----
// Result channel: valid/ready handshake with the result payload.
interface drb_out_if;
  logic               valid;
  logic               ready;
  logic               revealed_bit;
  logic               in_bounds;
  logic signed [17:0] center_x;
  logic signed [17:0] center_y;

  modport source (output valid, revealed_bit, in_bounds, center_x, center_y,
                  input ready);
  modport sink   (input valid, revealed_bit, in_bounds, center_x, center_y,
                  output ready);
endinterface

// ----- src/drb_div.sv -----
// Bit-serial floor divider of a signed offset by the cell size, saturated to the center range.
module drb_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [drb_pkg::DIV_W-1:0]    num,
  input  logic        [drb_pkg::DEN_W-1:0]    den,
  output logic                                done,
  output logic signed [drb_pkg::CTR_W-1:0]    quo
);

  logic                                run_r;
  logic                                fin_r;
  logic                                done_r;
  logic [drb_pkg::DIV_CNT_W-1:0]       cnt_r;
  logic                                neg_r;
  logic [drb_pkg::DIV_W-1:0]           dvd_r;
  logic [drb_pkg::DEN_W-1:0]           rem_r;
  logic [drb_pkg::DIV_W-1:0]           q_r;
  logic [drb_pkg::DEN_W-1:0]           den_r;
  logic signed [drb_pkg::CTR_W-1:0]    quo_r;

  logic [drb_pkg::DEN_W:0]             part;
  logic [drb_pkg::DEN_W+1:0]           diff;
  logic                                ge;
  logic [drb_pkg::DIV_W:0]             mag;
  logic [drb_pkg::CTR_W-2:0]           mag_sat;
  logic signed [drb_pkg::CTR_W-1:0]    quo_nxt;

  always_comb begin
    part = {rem_r, dvd_r[drb_pkg::DIV_W-1]};
    diff = {1'b0, part} - {2'b00, den_r};
    ge   = !diff[drb_pkg::DEN_W+1];
    mag  = {1'b0, q_r} + (drb_pkg::DIV_W+1)'(neg_r && (rem_r != '0));
    if (mag > (drb_pkg::DIV_W+1)'(drb_pkg::CENTER_LIMIT)) begin
      mag_sat = (drb_pkg::CTR_W-1)'(drb_pkg::CENTER_LIMIT);
    end else begin
      mag_sat = mag[drb_pkg::CTR_W-2:0];
    end
    quo_nxt = neg_r ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        fin_r <= 1'b0;
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[drb_pkg::DIV_W-1];
      dvd_r <= num[drb_pkg::DIV_W-1] ? drb_pkg::DIV_W'(-num) : drb_pkg::DIV_W'(num);
      rem_r <= '0;
      q_r   <= '0;
      den_r <= (den == '0) ? drb_pkg::DEN_W'(1) : den;
      cnt_r <= drb_pkg::DIV_CNT_W'(drb_pkg::DIV_W - 1);
    end else if (run_r) begin
      rem_r <= ge ? diff[drb_pkg::DEN_W-1:0] : part[drb_pkg::DEN_W-1:0];
      q_r   <= {q_r[drb_pkg::DIV_W-2:0], ge};
      dvd_r <= {dvd_r[drb_pkg::DIV_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end else if (fin_r) begin
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- src/disc_reveal_bitmap.sv -----
// Disc reveal bitmap: a memory of revealed grid cells updated by disc, cell and read commands.
//
// One command is worked at a time; each gives one result. For a reveal-disc command,
// two serial dividers find both center coordinates in parallel at one quotient bit
// per cycle, then the row memory is read, merged and written back at one grid row per
// cycle for the 2*radius+1 rows of the disc, followed by the drain state and the load
// state, which waits until the output register is empty or its result is taken.
// Reveal-cell and read-cell commands pass through the row, drain and load states; the
// unused command goes straight to the load state. The map holds one memory word per
// grid row with a valid bit per row, so reset clears it at once and no clearing pass is
// needed. The next command is taken while a finished result still waits in the output register.
module disc_reveal_bitmap (
  input  logic                                clk,
  input  logic                                rst_n,
  drb_in_if.sink                              in_ch,
  drb_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [drb_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [drb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ROWS,
    S_DRAIN,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]                        grid_cols_r;
  logic [6:0]                        grid_rows_r;
  logic signed [drb_pkg::WORLD_W-1:0] origin_x_r;
  logic signed [drb_pkg::WORLD_W-1:0] origin_y_r;
  logic [drb_pkg::DEN_W-1:0]         cell_size_r;

  logic [drb_pkg::COL_CW-1:0]        cols_eff;
  logic [6:0]                        rows_eff;

  drb_pkg::cmd_t                     cmd_r;
  logic [3:0]                        rad_r;
  logic [4:0]                        cnt_r;
  logic signed [drb_pkg::CTR_W-1:0]  ctr_x_r;
  logic signed [drb_pkg::CTR_W-1:0]  ctr_y_r;
  logic                              bit_r;

  logic                              out_vld_r;
  logic                              out_bit_r;
  logic                              out_inb_r;
  logic signed [drb_pkg::CTR_W-1:0]  out_cx_r;
  logic signed [drb_pkg::CTR_W-1:0]  out_cy_r;

  logic                              in_xfer;
  logic                              out_xfer;
  logic                              load_go;
  logic                              div_start;
  logic signed [drb_pkg::DIV_W-1:0]  num_x;
  logic signed [drb_pkg::DIV_W-1:0]  num_y;
  logic                              div_done_x;
  logic                              div_done_y;
  logic signed [drb_pkg::CTR_W-1:0]  quo_x;
  logic signed [drb_pkg::CTR_W-1:0]  quo_y;
  logic [3:0]                        rad_sat;

  logic signed [5:0]                 s0_dy;
  logic [3:0]                        s0_abs;
  logic [3:0]                        s0_w;
  logic signed [drb_pkg::POS_W-1:0]  s0_row;
  logic                              s0_row_ok;
  logic [drb_pkg::ROW_AW-1:0]        s0_idx;

  logic                              s1_vld_r;
  logic                              s1_wr_r;
  logic [drb_pkg::ROW_AW-1:0]        s1_row_r;
  logic signed [drb_pkg::POS_W-1:0]  s1_lo_r;
  logic signed [drb_pkg::POS_W-1:0]  s1_hi_r;
  logic                              rd_vld_r;
  logic [drb_pkg::MAX_COLS-1:0]      rd_data_r;
  logic [drb_pkg::MAX_COLS-1:0]      s1_old;
  logic [drb_pkg::MAX_COLS-1:0]      s1_mask;

  logic [drb_pkg::MAX_COLS-1:0]      map_mem [drb_pkg::MAX_ROWS];
  logic [drb_pkg::MAX_ROWS-1:0]      row_vld_r;

  logic                              inb;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_vld_r && out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign load_go   = (state_r == S_LOAD) && (!out_vld_r || out_ch.ready);
  assign div_start = in_xfer && (in_ch.cmd == drb_pkg::CMD_DISC);
  assign rad_sat   = (in_ch.radius > 4'(drb_pkg::MAX_RADIUS)) ?
                     4'(drb_pkg::MAX_RADIUS) : in_ch.radius;

  assign num_x = drb_pkg::DIV_W'(in_ch.world_x) - drb_pkg::DIV_W'(origin_x_r);
  assign num_y = drb_pkg::DIV_W'(in_ch.world_y) - drb_pkg::DIV_W'(origin_y_r);

  assign cols_eff = (grid_cols_r > 7'(drb_pkg::MAX_COLS)) ?
                    drb_pkg::COL_CW'(drb_pkg::MAX_COLS) : drb_pkg::COL_CW'(grid_cols_r);
  assign rows_eff = (grid_rows_r > 7'(drb_pkg::MAX_ROWS)) ?
                    7'(drb_pkg::MAX_ROWS) : grid_rows_r;

  drb_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_x),
    .den   (cell_size_r),
    .done  (div_done_x),
    .quo   (quo_x)
  );

  drb_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_y),
    .den   (cell_size_r),
    .done  (div_done_y),
    .quo   (quo_y)
  );

  // Row issue stage
  always_comb begin
    s0_dy     = $signed({1'b0, cnt_r}) - $signed({2'b00, rad_r});
    s0_abs    = s0_dy[5] ? 4'(-s0_dy) : 4'(s0_dy);
    s0_w      = drb_pkg::half_width(rad_r, s0_abs);
    s0_row    = drb_pkg::POS_W'(ctr_y_r) + drb_pkg::POS_W'(s0_dy);
    s0_row_ok = (s0_row >= 0) && (s0_row < $signed(drb_pkg::POS_W'(rows_eff)));
    s0_idx    = s0_row[drb_pkg::ROW_AW-1:0];
  end

  // Merge stage
  always_comb begin
    s1_old = rd_vld_r ? rd_data_r : '0;
    for (int i = 0; i < drb_pkg::MAX_COLS; i++) begin
      s1_mask[i] = ($signed(drb_pkg::POS_W'(i)) >= s1_lo_r) &&
                   ($signed(drb_pkg::POS_W'(i)) <= s1_hi_r) &&
                   (drb_pkg::COL_CW'(i) < cols_eff);
    end
  end

  always_comb begin
    inb = (cmd_r != drb_pkg::CMD_NONE) && (ctr_x_r >= 0) && (ctr_y_r >= 0) &&
          (ctr_x_r < $signed(drb_pkg::CTR_W'(cols_eff))) &&
          (ctr_y_r < $signed(drb_pkg::CTR_W'(rows_eff)));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_ch.cmd)
            drb_pkg::CMD_DISC: state_nxt = S_DIV;
            drb_pkg::CMD_NONE: state_nxt = S_LOAD;
            default:           state_nxt = S_ROWS;
          endcase
        end
      end
      S_DIV:   if (div_done_x && div_done_y) state_nxt = S_ROWS;
      S_ROWS:  if (cnt_r == {rad_r, 1'b0}) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_LOAD;
      S_LOAD:  if (load_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      s1_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= (state_r == S_ROWS) && s0_row_ok;
      if (load_go) begin
        out_vld_r <= 1'b1;
        out_bit_r <= bit_r;
        out_inb_r <= inb;
        out_cx_r  <= (cmd_r == drb_pkg::CMD_DISC) ? ctr_x_r : '0;
        out_cy_r  <= (cmd_r == drb_pkg::CMD_DISC) ? ctr_y_r : '0;
      end else if (out_xfer) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= in_ch.cmd;
      rad_r   <= (in_ch.cmd == drb_pkg::CMD_DISC) ? rad_sat : 4'd0;
      cnt_r   <= '0;
      bit_r   <= 1'b0;
      ctr_x_r <= drb_pkg::CTR_W'(in_ch.cell_x);
      ctr_y_r <= drb_pkg::CTR_W'(in_ch.cell_y);
    end else begin
      if ((state_r == S_DIV) && div_done_x && div_done_y) begin
        ctr_x_r <= quo_x;
        ctr_y_r <= quo_y;
      end
      if (state_r == S_ROWS) cnt_r <= cnt_r + 1'b1;
      if (s1_vld_r && !s1_wr_r) bit_r <= |(s1_old & s1_mask);
    end
    s1_wr_r  <= (cmd_r != drb_pkg::CMD_READ);
    s1_row_r <= s0_idx;
    s1_lo_r  <= drb_pkg::POS_W'(ctr_x_r) - drb_pkg::POS_W'(s0_w);
    s1_hi_r  <= drb_pkg::POS_W'(ctr_x_r) + drb_pkg::POS_W'(s0_w);
  end

  // Row memory: read in issue, write back in merge
  always_ff @(posedge clk) begin
    rd_data_r <= map_mem[s0_idx];
    if (s1_vld_r && s1_wr_r) map_mem[s1_row_r] <= s1_old | s1_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= row_vld_r[s0_idx];
      if (s1_vld_r && s1_wr_r) row_vld_r[s1_row_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= drb_pkg::RST_GRID_COLS;
      grid_rows_r <= drb_pkg::RST_GRID_ROWS;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      cell_size_r <= drb_pkg::RST_CELL_SIZE;
    end else if (cfg_we) begin
      case (cfg_idx)
        drb_pkg::REG_GRID_COLS: grid_cols_r <= cfg_wdata[6:0];
        drb_pkg::REG_GRID_ROWS: grid_rows_r <= cfg_wdata[6:0];
        drb_pkg::REG_ORIGIN_X:  origin_x_r  <= cfg_wdata[drb_pkg::WORLD_W-1:0];
        drb_pkg::REG_ORIGIN_Y:  origin_y_r  <= cfg_wdata[drb_pkg::WORLD_W-1:0];
        drb_pkg::REG_CELL_SIZE: cell_size_r <= cfg_wdata[drb_pkg::DEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.revealed_bit = out_bit_r;
  assign out_ch.in_bounds    = out_inb_r;
  assign out_ch.center_x     = out_cx_r;
  assign out_ch.center_y     = out_cy_r;

endmodule

// ----- src/drb_chk.sv -----
// Port checker of the disc reveal bitmap and its bind to the top level.
`include "disc_reveal_bitmap_defines.svh"

module drb_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_revealed_bit,
  input logic                                out_in_bounds,
  input logic signed [drb_pkg::CTR_W-1:0]    out_center_x,
  input logic signed [drb_pkg::CTR_W-1:0]    out_center_y
);

  logic                                center_zero;
  logic [2*drb_pkg::CTR_W+1:0]         out_payload;

  assign center_zero = (out_center_x == 0) && (out_center_y == 0);
  assign out_payload = {out_revealed_bit, out_in_bounds, out_center_x, out_center_y};

  `DRB_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  `DRB_ASSERT_NOW(a_bit_needs_bounds, out_valid && out_revealed_bit, out_in_bounds)
  `DRB_ASSERT_NOW(a_read_has_no_center, out_valid && out_revealed_bit, center_zero)
  `DRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `DRB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_payload))

endmodule

bind disc_reveal_bitmap drb_chk u_drb_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_revealed_bit (out_ch.revealed_bit),
  .out_in_bounds    (out_ch.in_bounds),
  .out_center_x     (out_ch.center_x),
  .out_center_y     (out_ch.center_y)
);

// ----- tb/tb_disc_reveal_bitmap.sv -----
`timescale 1ns / 1ps
// Testbench of disc_reveal_bitmap: directed and random commands checked against a bitmap predictor.
module tb_disc_reveal_bitmap;

  localparam int SETTLE_CYCLES = 2 * drb_pkg::MAX_RADIUS + 40;
  localparam int PHASE_ITEMS = 250;
  localparam int RANDOM_PHASES = 8;

  typedef struct {
    drb_pkg::cmd_t      cmd;
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic [3:0]         radius;
    logic signed [7:0]  cell_x;
    logic signed [7:0]  cell_y;
  } reveal_cmd_t;

  typedef struct {
    logic               revealed_bit;
    logic               in_bounds;
    logic signed [17:0] center_x;
    logic signed [17:0] center_y;
  } reveal_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [drb_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [drb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  drb_in_if in_ch ();
  drb_out_if out_ch ();

  disc_reveal_bitmap DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  logic [6:0]                   grid_cols_q;
  logic [6:0]                   grid_rows_q;
  logic signed [23:0]           origin_x_q;
  logic signed [23:0]           origin_y_q;
  logic [15:0]                  cell_size_q;
  logic [drb_pkg::MAX_COLS-1:0] revealed_rows [drb_pkg::MAX_ROWS];

  reveal_res_t pending_results [$];
  int n_errors = 0;
  int n_checked = 0;
  int n_settings = 0;
  int n_by_cmd [4] = '{0, 0, 0, 0};
  int burst_left = 0;
  bit sender_idles = 1'b1;
  int ready_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;

  function automatic int cols_used();
    return (grid_cols_q > drb_pkg::MAX_COLS) ? drb_pkg::MAX_COLS : int'(grid_cols_q);
  endfunction

  function automatic int rows_used();
    return (grid_rows_q > drb_pkg::MAX_ROWS) ? drb_pkg::MAX_ROWS : int'(grid_rows_q);
  endfunction

  function automatic bit cell_on_grid(longint x, longint y);
    return x >= 0 && y >= 0 && x < cols_used() && y < rows_used();
  endfunction

  function automatic longint floor_center(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    if (q > drb_pkg::CENTER_LIMIT) q = drb_pkg::CENTER_LIMIT;
    if (q < -drb_pkg::CENTER_LIMIT) q = -drb_pkg::CENTER_LIMIT;
    return q;
  endfunction

  // Work out the result of one command and update the revealed map.
  function automatic reveal_res_t apply_command(reveal_cmd_t c);
    reveal_res_t res;
    longint den;
    longint cx;
    longint cy;
    longint r;
    res = '{1'b0, 1'b0, 18'sd0, 18'sd0};
    case (c.cmd)
      drb_pkg::CMD_DISC: begin
        den = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
        r = (c.radius > drb_pkg::MAX_RADIUS) ? drb_pkg::MAX_RADIUS : longint'(c.radius);
        cx = floor_center(longint'(c.world_x) - longint'(origin_x_q), den);
        cy = floor_center(longint'(c.world_y) - longint'(origin_y_q), den);
        res.in_bounds = cell_on_grid(cx, cy);
        res.center_x = 18'(cx);
        res.center_y = 18'(cy);
        for (longint dx = -r; dx <= r; dx++) begin
          for (longint dy = -r; dy <= r; dy++) begin
            if (dx * dx + dy * dy <= r * r && cell_on_grid(cx + dx, cy + dy))
              revealed_rows[int'(cy + dy)][int'(cx + dx)] = 1'b1;
          end
        end
      end
      drb_pkg::CMD_CELL: begin
        res.in_bounds = cell_on_grid(c.cell_x, c.cell_y);
        if (res.in_bounds) revealed_rows[int'(c.cell_y)][int'(c.cell_x)] = 1'b1;
      end
      drb_pkg::CMD_READ: begin
        res.in_bounds = cell_on_grid(c.cell_x, c.cell_y);
        if (res.in_bounds) res.revealed_bit = revealed_rows[int'(c.cell_y)][int'(c.cell_x)];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic reveal_cmd_t make_cmd(drb_pkg::cmd_t op, longint wx, longint wy, int r,
                                           int x, int y);
    reveal_cmd_t c;
    c.cmd = op;
    c.world_x = 24'(wx);
    c.world_y = 24'(wy);
    c.radius = 4'(r);
    c.cell_x = 8'(x);
    c.cell_y = 8'(y);
    return c;
  endfunction

  // Mostly well-formed commands aimed at or near the grid, some raw noise.
  function automatic reveal_cmd_t random_cmd();
    reveal_cmd_t c;
    int pick;
    int r;
    longint den;
    longint tx;
    longint ty;
    pick = $urandom_range(0, 99);
    den = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
    r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
    if (pick < 10) begin
      c = make_cmd(pick < 5 ? drb_pkg::cmd_t'($urandom_range(0, 3)) : drb_pkg::CMD_NONE,
                   $urandom, $urandom, $urandom_range(0, 15), $urandom, $urandom);
    end else if (pick < 40) begin
      tx = longint'($urandom_range(0, cols_used() + 2 * r + 6)) - r - 3;
      ty = longint'($urandom_range(0, rows_used() + 2 * r + 6)) - r - 3;
      c = make_cmd(drb_pkg::CMD_DISC,
                   longint'(origin_x_q) + tx * den + $urandom_range(0, int'(den - 1)),
                   longint'(origin_y_q) + ty * den + $urandom_range(0, int'(den - 1)),
                   r, $urandom, $urandom);
    end else if (pick < 90 && $urandom_range(0, 9) != 0) begin
      c = make_cmd(pick < 60 ? drb_pkg::CMD_CELL : drb_pkg::CMD_READ, $urandom, $urandom,
                   $urandom_range(0, 15),
                   $urandom_range(0, cols_used() + 3) - 2,
                   $urandom_range(0, rows_used() + 3) - 2);
    end else begin
      c = make_cmd(pick < 60 ? drb_pkg::CMD_CELL : drb_pkg::CMD_READ, $urandom, $urandom,
                   $urandom_range(0, 15), $urandom, $urandom);
    end
    return c;
  endfunction

  task automatic reset_predictor();
    grid_cols_q = drb_pkg::RST_GRID_COLS;
    grid_rows_q = drb_pkg::RST_GRID_ROWS;
    origin_x_q = '0;
    origin_y_q = '0;
    cell_size_q = drb_pkg::RST_CELL_SIZE;
    foreach (revealed_rows[i]) revealed_rows[i] = '0;
  endtask

  task automatic write_reg(input logic [drb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [drb_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      drb_pkg::REG_GRID_COLS: grid_cols_q = data[6:0];
      drb_pkg::REG_GRID_ROWS: grid_rows_q = data[6:0];
      drb_pkg::REG_ORIGIN_X:  origin_x_q = data[23:0];
      drb_pkg::REG_ORIGIN_Y:  origin_y_q = data[23:0];
      drb_pkg::REG_CELL_SIZE: cell_size_q = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(input int cols, input int rows, input longint ox, input longint oy,
                          input int cs);
    wait_idle();
    write_reg(drb_pkg::REG_GRID_COLS, drb_pkg::CFG_DATA_W'(cols));
    write_reg(drb_pkg::REG_GRID_ROWS, drb_pkg::CFG_DATA_W'(rows));
    write_reg(drb_pkg::REG_ORIGIN_X, drb_pkg::CFG_DATA_W'(ox));
    write_reg(drb_pkg::REG_ORIGIN_Y, drb_pkg::CFG_DATA_W'(oy));
    write_reg(drb_pkg::REG_CELL_SIZE, drb_pkg::CFG_DATA_W'(cs));
    n_settings++;
  endtask

  // Send one command in bursts with random gaps; predict at the transfer.
  task automatic send_cmd(input reveal_cmd_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (sender_idles && $urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c.cmd;
    in_ch.world_x <= c.world_x;
    in_ch.world_y <= c.world_y;
    in_ch.radius <= c.radius;
    in_ch.cell_x <= c.cell_x;
    in_ch.cell_y <= c.cell_y;
    do @(posedge clk); while (!in_ch.ready);
    pending_results = {pending_results, apply_command(c)};
    n_by_cmd[int'(c.cmd)]++;
  endtask

  task automatic test_directed_commands();
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_CELL, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_CELL, 0, 0, 0, 63, 63));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 63, 63));
    send_cmd(make_cmd(drb_pkg::CMD_CELL, 0, 0, 0, -1, 0));
    send_cmd(make_cmd(drb_pkg::CMD_CELL, 0, 0, 0, 64, 0));
    send_cmd(make_cmd(drb_pkg::CMD_CELL, 0, 0, 0, -128, 127));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 127, -128));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 10 * 8192 + 100, 20 * 8192, 15, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 25, 20));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 11, 31));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 21, 31));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, -1, -1, 3, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 1, 1));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 8388607, -8388608, 15, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, -8388608, 8388607, 1, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_NONE, -1, -1, 15, -1, -1));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, -128, -128));
  endtask

  // Zero, saturated and shrunk grids; bits outside a shrunk grid must survive.
  task automatic test_grid_limits();
    set_grid(0, 0, 0, 0, 8192);
    send_cmd(make_cmd(drb_pkg::CMD_CELL, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 100, 100, 5, 0, 0));
    set_grid(127, 127, 0, 0, 8192);
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 63, 63));
    send_cmd(make_cmd(drb_pkg::CMD_CELL, 0, 0, 0, 64, 64));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 62 * 8192, 62 * 8192, 4, 0, 0));
    set_grid(4, 4, 0, 0, 8192);
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 10, 20));
    send_cmd(make_cmd(drb_pkg::CMD_CELL, 0, 0, 0, 3, 3));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 2 * 8192, 2 * 8192, 9, 0, 0));
    set_grid(65, 64, 0, 0, 8192);
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 10, 20));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 4, 4));
    set_grid(1, 64, 0, 0, 8192);
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 0, 20));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 1, 0));
    set_grid(64, 1, 0, 0, 8192);
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 30 * 8192, 0, 6, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_READ, 0, 0, 0, 36, 0));
  endtask

  // Cell sizes at and below one raw unit and up to the largest, and origins at the extremes.
  task automatic test_center_range();
    set_grid(64, 64, 0, 0, 0);
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 5, -7, 2, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 40, 50, 3, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 8388607, 8388607, 15, 0, 0));
    set_grid(64, 64, -8388608, 8388607, 1);
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 8388607, -8388608, 15, 0, 0));
    set_grid(64, 64, 8388607, -8388608, 65535);
    send_cmd(make_cmd(drb_pkg::CMD_DISC, -8388608, 8388607, 15, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 8388607 + 3 * 65535, -8388608 + 65534, 2, 0, 0));
    set_grid(64, 64, -1280, 1280, 255);
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 0, 0, 2, 0, 0));
    set_grid(64, 64, 0, 0, 256);
    send_cmd(make_cmd(drb_pkg::CMD_DISC, 63 * 256 + 255, 63 * 256 + 255, 1, 0, 0));
    send_cmd(make_cmd(drb_pkg::CMD_DISC, -1, 64 * 256, 0, 0, 0));
  endtask

  // Writes above the last register must change nothing.
  task automatic test_register_index();
    set_grid(20, 30, 1000, -2000, 700);
    for (int i = drb_pkg::REG_CELL_SIZE + 1; i < (1 << drb_pkg::CFG_IDX_W); i++)
      write_reg(drb_pkg::CFG_IDX_W'(i), drb_pkg::CFG_DATA_W'($urandom));
    write_reg(drb_pkg::REG_ORIGIN_X, '1);
    for (int i = drb_pkg::REG_CELL_SIZE + 1; i < (1 << drb_pkg::CFG_IDX_W); i++)
      write_reg(drb_pkg::CFG_IDX_W'(i), '1);
    repeat (20) send_cmd(random_cmd());
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_grid(64, 64, $urandom_range(0, 1 << 17) - (1 << 16), 0, 8192);
        1: set_grid($urandom_range(1, 64), $urandom_range(1, 64), $urandom, $urandom,
                    $urandom_range(256, 65535));
        2: set_grid(1, 1, $urandom, $urandom, $urandom_range(256, 1024));
        3: set_grid($urandom_range(65, 127), $urandom_range(65, 127), 0, 0, 256);
        4: set_grid(0, $urandom_range(0, 127), $urandom, $urandom, $urandom_range(256, 4096));
        5: set_grid(64, 64, $urandom, $urandom, $urandom_range(0, 255));
        6: set_grid($urandom_range(1, 64), 0, -8388608, 8388607, 65535);
        default: set_grid($urandom_range(0, 127), $urandom_range(0, 127), $urandom, $urandom,
                          $urandom_range(0, 65535));
      endcase
      sender_idles = (phase != 2);
      repeat (PHASE_ITEMS) send_cmd(random_cmd());
    end
    sender_idles = 1'b1;
  endtask

  // Receiver: check each transfer, then pick the next ready pattern.
  always @(posedge clk) begin : result_check
    reveal_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no command pending");
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_ch.revealed_bit !== want.revealed_bit) begin
          $error("revealed_bit: expected %0d, got %0d", want.revealed_bit, out_ch.revealed_bit);
          n_errors++;
        end
        if (out_ch.in_bounds !== want.in_bounds) begin
          $error("in_bounds: expected %0d, got %0d", want.in_bounds, out_ch.in_bounds);
          n_errors++;
        end
        if (out_ch.center_x !== want.center_x) begin
          $error("center_x: expected %0d, got %0d", want.center_x, out_ch.center_x);
          n_errors++;
        end
        if (out_ch.center_y !== want.center_y) begin
          $error("center_y: expected %0d, got %0d", want.center_y, out_ch.center_y);
          n_errors++;
        end
      end
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(32, 200);
    end
    mode_left--;
    stall_tick++;
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ((stall_tick % 7) < 4);
    endcase
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = drb_pkg::CMD_NONE;
    in_ch.world_x = '0;
    in_ch.world_y = '0;
    in_ch.radius = '0;
    in_ch.cell_x = '0;
    in_ch.cell_y = '0;
    out_ch.ready = 1'b0;
    reset_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_commands();
    test_grid_limits();
    test_center_range();
    test_register_index();
    test_random_settings();
    wait_idle();
    $display("Checked %0d results: %0d disc reveals, %0d cell reveals, %0d reads, %0d unused",
             n_checked, n_by_cmd[drb_pkg::CMD_DISC], n_by_cmd[drb_pkg::CMD_CELL],
             n_by_cmd[drb_pkg::CMD_READ], n_by_cmd[drb_pkg::CMD_NONE]);
    $display("over %0d grid settings, with %0d mismatches", n_settings, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
